// ===== hdl/gefr_pkg.sv =====
// Shared types and constants for the gated echo average framer.
// Used by every module in the block; depends on nothing else.
package gefr_pkg;

  localparam int EchoW = 16;
  localparam int DistW = 13;
  localparam int WarnW = 8;
  localparam int ByteW = 8;
  localparam int CfgIdxW = 2;
  localparam int CfgDataW = 13;

  localparam int DefSamplesPerWindow = 5;

  localparam logic [EchoW-1:0] TimeoutLimitUs = 16'd30000;
  localparam int MaxDistMm = 5100;

  // Distance is time * 17 / 100, done as a multiply by a rounded-up reciprocal.
  localparam int DistShift = 24;
  localparam int DistMulW = 22;
  localparam logic [DistMulW-1:0] DistMul = DistMulW'((17 * (2 ** DistShift) + 99) / 100);
  localparam int TimeW = 15;
  localparam int ProdW = TimeW + DistMulW;

  localparam logic [ByteW-1:0] FrameStart = 8'hAA;
  localparam logic [ByteW-1:0] FrameTypeDistance = 8'h01;

  localparam logic [DistW-1:0] ResetMinDist = 13'd250;
  localparam logic [DistW-1:0] ResetMaxDist = 13'd4500;
  localparam logic [WarnW-1:0] ResetWarnCount = 8'd10;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_MIN_DIST  = 2'd0,
    CFG_MAX_DIST  = 2'd1,
    CFG_WARN_CNT  = 2'd2
  } cfg_index_t;

  typedef enum logic [1:0] {
    F_IDLE,
    F_MUL,
    F_ACC
  } front_state_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_DIV,
    B_SEND
  } back_state_t;

  typedef enum logic [2:0] {
    POS_START,
    POS_TYPE,
    POS_HI,
    POS_LO,
    POS_CK
  } frame_pos_t;

  typedef enum logic {
    KIND_FRAME  = 1'b0,
    KIND_REPORT = 1'b1
  } result_kind_t;

  typedef struct packed {
    logic [DistW-1:0] min_dist;
    logic [DistW-1:0] max_dist;
    logic [WarnW-1:0] warn_cnt;
  } cfg_t;

  typedef struct packed {
    logic push;
    logic full;
  } q_ctl_t;

endpackage

// ===== hdl/gated_echo_average_framer.sv =====
// Gated echo average framer: one echo time per input beat, converted to millimetres and
// gated by the distance window. Each input beat passes through capture, reciprocal multiply
// and compare-and-accumulate states in the front part, which stalls its input until the beat
// is done; the last beat of a window waits only if both queue entries are full. The back
// part averages each window that kept a sample with a one-bit-per-cycle divider, then sends
// five frame beats, or one failure report for an empty window, one beat per cycle while
// out_stall is low. Configuration registers live here; uses gefr_pkg.
module gated_echo_average_framer #(
  parameter int SAMPLES_PER_WINDOW = gefr_pkg::DefSamplesPerWindow
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [gefr_pkg::EchoW-1:0]       in_echo_time_us,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic                             out_kind,
  output logic [gefr_pkg::ByteW-1:0]       out_data_byte,
  output logic                             out_last,
  output logic [gefr_pkg::WarnW-1:0]       out_fail_count,
  output logic                             out_warn,
  input  logic                             cfg_we,
  input  logic [gefr_pkg::CfgIdxW-1:0]     cfg_index,
  input  logic [gefr_pkg::CfgDataW-1:0]    cfg_data
);

  localparam int SUM_W = $clog2(gefr_pkg::MaxDistMm * SAMPLES_PER_WINDOW + 1);
  localparam int CNT_W = $clog2(SAMPLES_PER_WINDOW + 1);
  localparam int QW = SUM_W + CNT_W;

  gefr_pkg::cfg_t   cfg_r, cfg_nxt;
  gefr_pkg::q_ctl_t q_ctl;
  logic             q_full;
  logic             q_empty;
  logic             q_pop;
  logic [QW-1:0]    q_wr_data;
  logic [QW-1:0]    q_rd_data;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        gefr_pkg::CFG_MIN_DIST: cfg_nxt.min_dist = cfg_data;
        gefr_pkg::CFG_MAX_DIST: cfg_nxt.max_dist = cfg_data;
        gefr_pkg::CFG_WARN_CNT: cfg_nxt.warn_cnt = cfg_data[gefr_pkg::WarnW-1:0];
        default: cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.min_dist <= gefr_pkg::ResetMinDist;
      cfg_r.max_dist <= gefr_pkg::ResetMaxDist;
      cfg_r.warn_cnt <= gefr_pkg::ResetWarnCount;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  gefr_front #(
    .SAMPLES_PER_WINDOW(SAMPLES_PER_WINDOW),
    .SUM_W(SUM_W),
    .CNT_W(CNT_W)
  ) u_front (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_echo_time_us(in_echo_time_us),
    .cfg(cfg_r),
    .q_ctl(q_ctl),
    .q_full(q_full),
    .q_data(q_wr_data)
  );

  gefr_queue #(
    .W(QW)
  ) u_queue (
    .clk(clk),
    .rst_n(rst_n),
    .ctl_in(q_ctl),
    .full(q_full),
    .wr_data(q_wr_data),
    .pop(q_pop),
    .empty(q_empty),
    .rd_data(q_rd_data)
  );

  gefr_back #(
    .SUM_W(SUM_W),
    .CNT_W(CNT_W)
  ) u_back (
    .clk(clk),
    .rst_n(rst_n),
    .q_empty(q_empty),
    .q_data(q_rd_data),
    .q_pop(q_pop),
    .cfg(cfg_r),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_kind(out_kind),
    .out_data_byte(out_data_byte),
    .out_last(out_last),
    .out_fail_count(out_fail_count),
    .out_warn(out_warn)
  );

endmodule

// ===== hdl/gefr_queue.sv =====
// Two-entry queue of window summaries between the front and back parts.
// Generic in its entry width; uses gefr_pkg for the push/full control struct.
module gefr_queue #(
  parameter int W = 8
) (
  input  logic           clk,
  input  logic           rst_n,
  input  gefr_pkg::q_ctl_t ctl_in,
  output logic           full,
  input  logic [W-1:0]   wr_data,
  input  logic           pop,
  output logic           empty,
  output logic [W-1:0]   rd_data
);

  logic [W-1:0] mem [2];
  logic         wr_ptr_r, wr_ptr_nxt;
  logic         rd_ptr_r, rd_ptr_nxt;
  logic [1:0]   fill_r, fill_nxt;
  logic         do_push, do_pop;

  assign full = (fill_r == 2'd2);
  assign empty = (fill_r == 2'd0);
  assign do_push = ctl_in.push && !full;
  assign do_pop = pop && !empty;
  assign rd_data = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = do_push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop ? ~rd_ptr_r : rd_ptr_r;
    fill_nxt = fill_r + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      fill_r <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= wr_data;
    end
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r != 2'd3) else $error("queue fill count out of range");
  a_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    ctl_in.push |-> !full) else $error("push into a full queue");
  a_pop_moves: assert property (@(posedge clk) disable iff (!rst_n)
    (do_pop && !do_push) |=> (fill_r == $past(fill_r) - 2'd1))
    else $error("pop did not reduce the fill count");

endmodule

// ===== hdl/gefr_front.sv =====
// Front part: takes echo times, converts them to distances, gates and sums them.
// At the end of each window it pushes the sum and count into the queue; uses gefr_pkg.
module gefr_front #(
  parameter int SAMPLES_PER_WINDOW = gefr_pkg::DefSamplesPerWindow,
  parameter int SUM_W = 17,
  parameter int CNT_W = 3
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [gefr_pkg::EchoW-1:0]    in_echo_time_us,
  input  gefr_pkg::cfg_t                cfg,
  output gefr_pkg::q_ctl_t              q_ctl,
  input  logic                          q_full,
  output logic [SUM_W+CNT_W-1:0]        q_data
);

  localparam int IDX_W = (SAMPLES_PER_WINDOW > 1) ? $clog2(SAMPLES_PER_WINDOW) : 1;

  gefr_pkg::front_state_t state_r, state_nxt;

  logic [gefr_pkg::TimeW-1:0] time_r, time_nxt;
  logic                       tout_r, tout_nxt;
  logic [gefr_pkg::ProdW-1:0] prod_r, prod_nxt;
  logic [SUM_W-1:0]           sum_r, sum_nxt;
  logic [CNT_W-1:0]           cnt_r, cnt_nxt;
  logic [IDX_W-1:0]           idx_r, idx_nxt;

  logic [gefr_pkg::DistW-1:0] dist_mm;
  logic                       keep;
  logic                       win_end;
  logic [SUM_W-1:0]           sum_add;
  logic [CNT_W-1:0]           cnt_add;
  logic                       accept;

  assign accept = in_valid && !in_stall;
  assign dist_mm = prod_r[gefr_pkg::ProdW-1 -: gefr_pkg::DistW];
  assign keep = !tout_r && (dist_mm >= cfg.min_dist) && (dist_mm <= cfg.max_dist);
  assign win_end = (idx_r == IDX_W'(SAMPLES_PER_WINDOW - 1));
  assign sum_add = sum_r + (keep ? SUM_W'(dist_mm) : SUM_W'(0));
  assign cnt_add = cnt_r + (keep ? CNT_W'(1) : CNT_W'(0));
  assign q_data = {sum_add, cnt_add};

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      gefr_pkg::F_IDLE: begin
        if (accept) begin
          state_nxt = gefr_pkg::F_MUL;
        end
      end
      gefr_pkg::F_MUL: state_nxt = gefr_pkg::F_ACC;
      gefr_pkg::F_ACC: begin
        if (!(win_end && q_full)) begin
          state_nxt = gefr_pkg::F_IDLE;
        end
      end
      default: state_nxt = gefr_pkg::F_IDLE;
    endcase
  end

  always_comb begin
    in_stall = (state_r != gefr_pkg::F_IDLE);
    q_ctl.push = 1'b0;
    q_ctl.full = q_full;
    time_nxt = time_r;
    tout_nxt = tout_r;
    prod_nxt = prod_r;
    sum_nxt = sum_r;
    cnt_nxt = cnt_r;
    idx_nxt = idx_r;
    case (state_r)
      gefr_pkg::F_IDLE: begin
        if (accept) begin
          time_nxt = in_echo_time_us[gefr_pkg::TimeW-1:0];
          tout_nxt = (in_echo_time_us == '0) ||
                     (in_echo_time_us > gefr_pkg::TimeoutLimitUs);
        end
      end
      gefr_pkg::F_MUL: begin
        prod_nxt = gefr_pkg::ProdW'(time_r) * gefr_pkg::ProdW'(gefr_pkg::DistMul);
      end
      gefr_pkg::F_ACC: begin
        if (win_end) begin
          if (!q_full) begin
            q_ctl.push = 1'b1;
            sum_nxt = '0;
            cnt_nxt = '0;
            idx_nxt = '0;
          end
        end else begin
          sum_nxt = sum_add;
          cnt_nxt = cnt_add;
          idx_nxt = idx_r + IDX_W'(1);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= gefr_pkg::F_IDLE;
      sum_r <= '0;
      cnt_r <= '0;
      idx_r <= '0;
    end else begin
      state_r <= state_nxt;
      sum_r <= sum_nxt;
      cnt_r <= cnt_nxt;
      idx_r <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    time_r <= time_nxt;
    tout_r <= tout_nxt;
    prod_r <= prod_nxt;
  end

  a_push_at_end: assert property (@(posedge clk) disable iff (!rst_n)
    q_ctl.push |-> win_end) else $error("window pushed before its last sample");
  a_idle_after_push: assert property (@(posedge clk) disable iff (!rst_n)
    q_ctl.push |=> (state_r == gefr_pkg::F_IDLE && idx_r == '0 && cnt_r == '0))
    else $error("window state not cleared after push");
  a_index_bound: assert property (@(posedge clk) disable iff (!rst_n)
    idx_r <= IDX_W'(SAMPLES_PER_WINDOW - 1)) else $error("sample index out of range");

endmodule

// ===== hdl/gefr_back.sv =====
// Back part: takes window summaries from the queue, averages them with a
// shift-subtract divider and sends the frame bytes or a failure report; uses gefr_pkg.
module gefr_back #(
  parameter int SUM_W = 17,
  parameter int CNT_W = 3
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          q_empty,
  input  logic [SUM_W+CNT_W-1:0]        q_data,
  output logic                          q_pop,
  input  gefr_pkg::cfg_t                cfg,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          out_kind,
  output logic [gefr_pkg::ByteW-1:0]    out_data_byte,
  output logic                          out_last,
  output logic [gefr_pkg::WarnW-1:0]    out_fail_count,
  output logic                          out_warn
);

  localparam int STEP_W = $clog2(SUM_W);

  gefr_pkg::back_state_t state_r, state_nxt;
  gefr_pkg::frame_pos_t  pos_r, pos_nxt;

  logic [SUM_W-1:0]           quo_r, quo_nxt;
  logic [CNT_W-1:0]           rem_r, rem_nxt;
  logic [CNT_W-1:0]           div_r, div_nxt;
  logic [STEP_W-1:0]          step_r, step_nxt;
  logic                       report_r, report_nxt;
  logic [gefr_pkg::WarnW-1:0] fails_r, fails_nxt;

  logic                       out_valid_r, out_valid_nxt;
  logic                       out_kind_r, out_kind_nxt;
  logic [gefr_pkg::ByteW-1:0] out_data_r, out_data_nxt;
  logic                       out_last_r, out_last_nxt;
  logic [gefr_pkg::WarnW-1:0] out_fail_r, out_fail_nxt;
  logic                       out_warn_r, out_warn_nxt;

  logic [SUM_W-1:0]           q_sum;
  logic [CNT_W-1:0]           q_cnt;
  logic [CNT_W:0]             trial;
  logic                       ge;
  logic [15:0]                avg;
  logic [gefr_pkg::ByteW-1:0] csum;
  logic                       slot_free;
  logic                       load;
  logic                       div_done;

  assign q_sum = q_data[SUM_W+CNT_W-1:CNT_W];
  assign q_cnt = q_data[CNT_W-1:0];
  assign trial = {rem_r, quo_r[SUM_W-1]};
  assign ge = (trial >= {1'b0, div_r});
  assign avg = 16'(quo_r);
  assign csum = gefr_pkg::FrameStart + gefr_pkg::FrameTypeDistance + avg[15:8] + avg[7:0];
  assign slot_free = !out_valid_r || !out_stall;
  assign div_done = (step_r == STEP_W'(SUM_W - 1));

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      gefr_pkg::B_IDLE: begin
        if (!q_empty) begin
          state_nxt = (q_cnt == '0) ? gefr_pkg::B_SEND : gefr_pkg::B_DIV;
        end
      end
      gefr_pkg::B_DIV: begin
        if (div_done) begin
          state_nxt = gefr_pkg::B_SEND;
        end
      end
      gefr_pkg::B_SEND: begin
        if (slot_free && (report_r || pos_r == gefr_pkg::POS_CK)) begin
          state_nxt = gefr_pkg::B_IDLE;
        end
      end
      default: state_nxt = gefr_pkg::B_IDLE;
    endcase
  end

  always_comb begin
    q_pop = 1'b0;
    load = 1'b0;
    pos_nxt = pos_r;
    quo_nxt = quo_r;
    rem_nxt = rem_r;
    div_nxt = div_r;
    step_nxt = step_r;
    report_nxt = report_r;
    fails_nxt = fails_r;
    out_kind_nxt = out_kind_r;
    out_data_nxt = out_data_r;
    out_last_nxt = out_last_r;
    out_fail_nxt = out_fail_r;
    out_warn_nxt = out_warn_r;
    case (state_r)
      gefr_pkg::B_IDLE: begin
        if (!q_empty) begin
          q_pop = 1'b1;
          quo_nxt = q_sum;
          rem_nxt = '0;
          div_nxt = q_cnt;
          step_nxt = '0;
          pos_nxt = gefr_pkg::POS_START;
          if (q_cnt == '0) begin
            report_nxt = 1'b1;
            fails_nxt = fails_r + gefr_pkg::WarnW'(1);
          end else begin
            report_nxt = 1'b0;
            fails_nxt = '0;
          end
        end
      end
      gefr_pkg::B_DIV: begin
        quo_nxt = {quo_r[SUM_W-2:0], ge};
        rem_nxt = ge ? CNT_W'(trial - {1'b0, div_r}) : CNT_W'(trial);
        step_nxt = step_r + STEP_W'(1);
      end
      gefr_pkg::B_SEND: begin
        if (slot_free) begin
          load = 1'b1;
          if (report_r) begin
            out_kind_nxt = gefr_pkg::KIND_REPORT;
            out_data_nxt = '0;
            out_last_nxt = 1'b1;
            out_fail_nxt = fails_r;
            out_warn_nxt = (fails_r == cfg.warn_cnt);
          end else begin
            out_kind_nxt = gefr_pkg::KIND_FRAME;
            out_fail_nxt = '0;
            out_warn_nxt = 1'b0;
            out_last_nxt = (pos_r == gefr_pkg::POS_CK);
            case (pos_r)
              gefr_pkg::POS_START: begin
                out_data_nxt = gefr_pkg::FrameStart;
                pos_nxt = gefr_pkg::POS_TYPE;
              end
              gefr_pkg::POS_TYPE: begin
                out_data_nxt = gefr_pkg::FrameTypeDistance;
                pos_nxt = gefr_pkg::POS_HI;
              end
              gefr_pkg::POS_HI: begin
                out_data_nxt = avg[15:8];
                pos_nxt = gefr_pkg::POS_LO;
              end
              gefr_pkg::POS_LO: begin
                out_data_nxt = avg[7:0];
                pos_nxt = gefr_pkg::POS_CK;
              end
              gefr_pkg::POS_CK: begin
                out_data_nxt = csum;
                pos_nxt = gefr_pkg::POS_START;
              end
              default: begin
                out_data_nxt = '0;
                pos_nxt = gefr_pkg::POS_START;
              end
            endcase
          end
        end
      end
      default: begin
      end
    endcase
    out_valid_nxt = load || (out_valid_r && out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= gefr_pkg::B_IDLE;
      fails_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      fails_r <= fails_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pos_r <= pos_nxt;
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    div_r <= div_nxt;
    step_r <= step_nxt;
    report_r <= report_nxt;
    out_kind_r <= out_kind_nxt;
    out_data_r <= out_data_nxt;
    out_last_r <= out_last_nxt;
    out_fail_r <= out_fail_nxt;
    out_warn_r <= out_warn_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_kind = out_kind_r;
  assign out_data_byte = out_data_r;
  assign out_last = out_last_r;
  assign out_fail_count = out_fail_r;
  assign out_warn = out_warn_r;

  a_report_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_kind_r) |-> out_last_r) else $error("failure report without last");
  a_warn_only_report: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_warn_r) |-> out_kind_r) else $error("warn raised on a frame beat");
  a_frame_clears_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_kind_r) |-> (out_fail_r == '0))
    else $error("frame beat with a non-zero failure count");
  a_pop_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> (state_r == gefr_pkg::B_IDLE && !q_empty)) else $error("pop outside idle");

endmodule

// ===== dv/gefr_frame_checker.sv =====
// Checker for the gated echo average framer: it watches the echo, result and register ports,
// keeps its own model of the window state and compares every result beat in order.
// Depends on gefr_pkg; instantiated beside the block by tb_gated_echo_average_framer.
module gefr_frame_checker #(
  parameter int SAMPLES_PER_WINDOW = gefr_pkg::DefSamplesPerWindow
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic                          in_stall,
  input  logic [gefr_pkg::EchoW-1:0]    in_echo_time_us,
  input  logic                          out_valid,
  input  logic                          out_stall,
  input  logic                          out_kind,
  input  logic [gefr_pkg::ByteW-1:0]    out_data_byte,
  input  logic                          out_last,
  input  logic [gefr_pkg::WarnW-1:0]    out_fail_count,
  input  logic                          out_warn,
  input  logic                          cfg_we,
  input  logic [gefr_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [gefr_pkg::CfgDataW-1:0] cfg_data,
  output int                            mismatches,
  output int                            pending,
  output int                            results_seen,
  output int                            reports_seen,
  output int                            warns_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MmPerUsNum = 17;
  localparam int MmPerUsDen = 100;

  typedef struct packed {
    gefr_pkg::result_kind_t     kind;
    logic [gefr_pkg::ByteW-1:0] data_byte;
    logic                       last;
    logic [gefr_pkg::WarnW-1:0] fail_count;
    logic                       warn;
  } echo_result_t;

  logic [gefr_pkg::DistW-1:0] gate_min_mm;
  logic [gefr_pkg::DistW-1:0] gate_max_mm;
  logic [gefr_pkg::WarnW-1:0] warn_at;
  logic [gefr_pkg::WarnW-1:0] fail_run;
  int                         window_pos;
  int                         kept_sum;
  int                         kept_count;
  echo_result_t               due_results[$];

  task automatic note_mismatch(input string what);
    $display("%0t ns  MISMATCH: %s", $time, what);
    mismatches++;
  endtask

  function automatic echo_result_t frame_beat(input logic [gefr_pkg::ByteW-1:0] b,
                                              input logic is_last);
    echo_result_t r;
    r.kind       = gefr_pkg::KIND_FRAME;
    r.data_byte  = b;
    r.last       = is_last;
    r.fail_count = '0;
    r.warn       = 1'b0;
    return r;
  endfunction

  task automatic accumulate_echo(input logic [gefr_pkg::EchoW-1:0] echo);
    int                         dist_mm;
    int                         avg_mm;
    logic [gefr_pkg::ByteW-1:0] hi;
    logic [gefr_pkg::ByteW-1:0] lo;
    logic [gefr_pkg::ByteW-1:0] ck;
    echo_result_t               rep;
    if (echo != '0 && echo <= gefr_pkg::TimeoutLimitUs) begin
      dist_mm = int'(echo) * MmPerUsNum / MmPerUsDen;
      if (dist_mm >= int'(gate_min_mm) && dist_mm <= int'(gate_max_mm)) begin
        kept_sum += dist_mm;
        kept_count++;
      end
    end
    window_pos++;
    if (window_pos == SAMPLES_PER_WINDOW) begin
      if (kept_count > 0) begin
        avg_mm = kept_sum / kept_count;
        hi = gefr_pkg::ByteW'(avg_mm >> 8);
        lo = gefr_pkg::ByteW'(avg_mm);
        ck = gefr_pkg::FrameStart + gefr_pkg::FrameTypeDistance + hi + lo;
        fail_run = '0;
        due_results.push_back(frame_beat(gefr_pkg::FrameStart, 1'b0));
        due_results.push_back(frame_beat(gefr_pkg::FrameTypeDistance, 1'b0));
        due_results.push_back(frame_beat(hi, 1'b0));
        due_results.push_back(frame_beat(lo, 1'b0));
        due_results.push_back(frame_beat(ck, 1'b1));
      end else begin
        fail_run       = fail_run + 1'b1;
        rep.kind       = gefr_pkg::KIND_REPORT;
        rep.data_byte  = '0;
        rep.last       = 1'b1;
        rep.fail_count = fail_run;
        rep.warn       = (fail_run == warn_at);
        due_results.push_back(rep);
      end
      window_pos = 0;
      kept_sum   = 0;
      kept_count = 0;
    end
  endtask

  always @(posedge clk) begin
    echo_result_t want;
    if (!rst_n) begin
      gate_min_mm  = gefr_pkg::ResetMinDist;
      gate_max_mm  = gefr_pkg::ResetMaxDist;
      warn_at      = gefr_pkg::ResetWarnCount;
      fail_run     = '0;
      window_pos   = 0;
      kept_sum     = 0;
      kept_count   = 0;
      due_results.delete();
      pending      = 0;
      mismatches   = 0;
      results_seen = 0;
      reports_seen = 0;
      warns_seen   = 0;
    end else begin
      if (out_valid && !out_stall) begin
        results_seen++;
        if (due_results.size() == 0) begin
          note_mismatch($sformatf("result beat with nothing expected (kind %0b, byte %02h)",
                                  out_kind, out_data_byte));
        end else begin
          want = due_results.pop_front();
          if (out_kind !== want.kind)
            note_mismatch($sformatf("kind %0b, expected %0b", out_kind, want.kind));
          if (out_data_byte !== want.data_byte)
            note_mismatch($sformatf("data byte %02h, expected %02h", out_data_byte,
                                    want.data_byte));
          if (out_last !== want.last)
            note_mismatch($sformatf("last %0b, expected %0b", out_last, want.last));
          if (out_fail_count !== want.fail_count)
            note_mismatch($sformatf("fail count %0d, expected %0d", out_fail_count,
                                    want.fail_count));
          if (out_warn !== want.warn)
            note_mismatch($sformatf("warn %0b, expected %0b", out_warn, want.warn));
          if (want.kind == gefr_pkg::KIND_REPORT) reports_seen++;
          if (want.warn) warns_seen++;
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          gefr_pkg::CFG_MIN_DIST: gate_min_mm = cfg_data;
          gefr_pkg::CFG_MAX_DIST: gate_max_mm = cfg_data;
          gefr_pkg::CFG_WARN_CNT: warn_at = cfg_data[gefr_pkg::WarnW-1:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) accumulate_echo(in_echo_time_us);
      pending = due_results.size();
    end
  end

endmodule

// ===== dv/tb_gated_echo_average_framer.sv =====
// Top of the framer testbench: clock, reset, echo and register stimulus, output stalls and
// the verdict. Depends on gefr_pkg, the block and gefr_frame_checker.
module tb_gated_echo_average_framer;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ClkPeriod    = 20;
  localparam int LimitCycles  = 1_000_000;
  localparam int SettleCycles = 40;
  localparam int HoldCycles   = 300;
  localparam int WindowLen    = gefr_pkg::DefSamplesPerWindow;
  localparam int MmPerUsNum   = 17;
  localparam int MmPerUsDen   = 100;
  localparam int TimeoutUs    = int'(gefr_pkg::TimeoutLimitUs);
  localparam logic [gefr_pkg::CfgIdxW-1:0] CfgUnusedIdx = 2'd3;

  typedef enum int {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HEAVY
  } stall_mode_t;

  logic                          clk;
  logic                          rst_n;
  logic                          in_valid;
  logic                          in_stall;
  logic [gefr_pkg::EchoW-1:0]    in_echo_time_us;
  logic                          out_valid;
  logic                          out_stall;
  logic                          out_kind;
  logic [gefr_pkg::ByteW-1:0]    out_data_byte;
  logic                          out_last;
  logic [gefr_pkg::WarnW-1:0]    out_fail_count;
  logic                          out_warn;
  logic                          cfg_we;
  logic [gefr_pkg::CfgIdxW-1:0]  cfg_index;
  logic [gefr_pkg::CfgDataW-1:0] cfg_data;

  int mismatches;
  int pending;
  int results_seen;
  int reports_seen;
  int warns_seen;
  int hold_requests;
  int hold_served;
  int echoes_sent;
  int burst_left;

  logic [gefr_pkg::DistW-1:0] cur_min_mm;
  logic [gefr_pkg::DistW-1:0] cur_max_mm;

  gated_echo_average_framer #(
    .SAMPLES_PER_WINDOW(WindowLen)
  ) dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_echo_time_us(in_echo_time_us),
    .out_valid(out_valid), .out_stall(out_stall), .out_kind(out_kind),
    .out_data_byte(out_data_byte), .out_last(out_last), .out_fail_count(out_fail_count),
    .out_warn(out_warn),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  gefr_frame_checker #(
    .SAMPLES_PER_WINDOW(WindowLen)
  ) frame_check (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_echo_time_us(in_echo_time_us),
    .out_valid(out_valid), .out_stall(out_stall), .out_kind(out_kind),
    .out_data_byte(out_data_byte), .out_last(out_last), .out_fail_count(out_fail_count),
    .out_warn(out_warn),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .mismatches(mismatches), .pending(pending), .results_seen(results_seen),
    .reports_seen(reports_seen), .warns_seen(warns_seen)
  );

  initial begin
    clk = 1'b0;
    forever #(ClkPeriod / 2) clk = ~clk;
  end

  initial begin
    #(LimitCycles * ClkPeriod);
    $display("simulation failed");
    $finish;
  end

  // Smallest echo time that converts to at least mm, moved by nudge and kept in range.
  function automatic logic [gefr_pkg::EchoW-1:0] echo_for_mm(input int mm, input int nudge);
    int t;
    t = (mm * MmPerUsDen + MmPerUsNum - 1) / MmPerUsNum + nudge;
    if (t < 1) t = 1;
    if (t > TimeoutUs) t = TimeoutUs;
    return gefr_pkg::EchoW'(t);
  endfunction

  function automatic logic [gefr_pkg::EchoW-1:0] random_echo();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 8) return '0;
    if (pick < 16) return gefr_pkg::EchoW'($urandom_range(TimeoutUs + 1, 65535));
    if (pick < 28) return echo_for_mm(int'(cur_min_mm), int'($urandom_range(0, 4)) - 2);
    if (pick < 40) return echo_for_mm(int'(cur_max_mm), int'($urandom_range(0, 4)) - 2);
    return gefr_pkg::EchoW'($urandom_range(1, TimeoutUs));
  endfunction

  task automatic send_echo(input logic [gefr_pkg::EchoW-1:0] echo);
    in_valid        <= 1'b1;
    in_echo_time_us <= echo;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    echoes_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 8);
      in_valid        <= 1'b0;
      in_echo_time_us <= gefr_pkg::EchoW'($urandom);
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  endtask

  task automatic wait_for_quiet();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic write_reg(input logic [gefr_pkg::CfgIdxW-1:0] idx,
                           input logic [gefr_pkg::CfgDataW-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    if (idx == gefr_pkg::CFG_MIN_DIST) cur_min_mm = value;
    else if (idx == gefr_pkg::CFG_MAX_DIST) cur_max_mm = value;
  endtask

  initial begin
    stall_mode_t stall_mode;
    int          mode_left;
    out_stall   = 1'b0;
    hold_served = 0;
    stall_mode  = STALL_NONE;
    mode_left   = 0;
    forever begin
      @(posedge clk);
      if (hold_served < hold_requests) begin
        out_stall <= 1'b1;
        repeat (HoldCycles) @(posedge clk);
        hold_served++;
      end else begin
        if (mode_left == 0) begin
          stall_mode = stall_mode_t'($urandom_range(0, 2));
          mode_left  = $urandom_range(4, 80);
        end
        mode_left--;
        case (stall_mode)
          STALL_NONE:  out_stall <= 1'b0;
          STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
          default:     out_stall <= ($urandom_range(0, 3) != 0);
        endcase
      end
    end
  end

  initial begin
    logic [gefr_pkg::EchoW-1:0] batch[$];
    logic [gefr_pkg::DistW-1:0] lo_mm;
    logic [gefr_pkg::DistW-1:0] hi_mm;
    int                         gate_mode;
    int                         phase_items;
    int                         quiet_at;
    rst_n           = 1'b0;
    in_valid        = 1'b0;
    in_echo_time_us = '0;
    cfg_we          = 1'b0;
    cfg_index       = '0;
    cfg_data        = '0;
    hold_requests   = 0;
    echoes_sent     = 0;
    burst_left      = 0;
    cur_min_mm      = gefr_pkg::ResetMinDist;
    cur_max_mm      = gefr_pkg::ResetMaxDist;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset gate: a window with nothing kept, then one that probes both gate edges.
    batch = '{16'd0, 16'hFFFF, gefr_pkg::TimeoutLimitUs + 16'd1, gefr_pkg::TimeoutLimitUs,
              16'd1,
              echo_for_mm(int'(gefr_pkg::ResetMinDist), 0),
              echo_for_mm(int'(gefr_pkg::ResetMinDist), -1),
              echo_for_mm(int'(gefr_pkg::ResetMaxDist), 0),
              echo_for_mm(int'(gefr_pkg::ResetMaxDist) + 1, 0),
              16'd20000};
    foreach (batch[i]) send_echo(batch[i]);
    wait_for_quiet();

    // Fully open gate: timeouts alone still fail, a zero average still makes a frame.
    write_reg(gefr_pkg::CFG_MIN_DIST, '0);
    write_reg(gefr_pkg::CFG_MAX_DIST, '1);
    write_reg(gefr_pkg::CFG_WARN_CNT, '0);
    batch = '{16'd0, gefr_pkg::TimeoutLimitUs + 16'd1, 16'hFFFF, 16'd40000, 16'd0,
              16'd1, 16'd2, 16'd5, 16'd0, 16'hFFFF,
              gefr_pkg::TimeoutLimitUs, gefr_pkg::TimeoutLimitUs,
              gefr_pkg::TimeoutLimitUs - 16'd1, 16'd1, 16'd0};
    foreach (batch[i]) send_echo(batch[i]);
    wait_for_quiet();

    // Inverted gate: every window fails, so the count climbs through the warn level.
    write_reg(gefr_pkg::CFG_MIN_DIST, '1);
    write_reg(gefr_pkg::CFG_MAX_DIST, '0);
    write_reg(gefr_pkg::CFG_WARN_CNT, 13'd7);
    repeat (12 * WindowLen) send_echo(gefr_pkg::EchoW'($urandom));
    wait_for_quiet();
    write_reg(gefr_pkg::CFG_WARN_CNT, '0);
    write_reg(CfgUnusedIdx, '1);
    repeat (WindowLen) send_echo(gefr_pkg::EchoW'($urandom));
    wait_for_quiet();

    for (int p = 0; p < 6; p++) begin
      gate_mode = $urandom_range(0, 3);
      if (gate_mode == 0) begin
        lo_mm = gefr_pkg::DistW'($urandom_range(0, 600));
        hi_mm = gefr_pkg::DistW'($urandom_range(3000, 8191));
      end else if (gate_mode == 1) begin
        lo_mm = gefr_pkg::DistW'($urandom_range(0, 5000));
        hi_mm = lo_mm + gefr_pkg::DistW'($urandom_range(0, 200));
      end else if (gate_mode == 2) begin
        lo_mm = gefr_pkg::DistW'($urandom);
        hi_mm = gefr_pkg::DistW'($urandom);
      end else begin
        lo_mm = '0;
        hi_mm = '1;
      end
      write_reg(gefr_pkg::CFG_MIN_DIST, lo_mm);
      write_reg(gefr_pkg::CFG_MAX_DIST, hi_mm);
      write_reg(gefr_pkg::CFG_WARN_CNT, {5'($urandom), ($urandom_range(0, 3) == 0) ?
                                         8'($urandom) : 8'($urandom_range(0, 3))});
      phase_items = $urandom_range(40, 60);
      quiet_at    = $urandom_range(5, phase_items - 5);
      for (int i = 0; i < phase_items; i++) begin
        if (p == 2 && i == 10) hold_requests++;
        if (i == quiet_at && !(p == 2 && i >= 10)) wait_for_quiet();
        send_echo(random_echo());
      end
      wait_for_quiet();
    end

    $display("%0d echo beats sent, %0d result beats checked, %0d failure reports, %0d warned.",
             echoes_sent, results_seen, reports_seen, warns_seen);
    $display("Gate edges, timeouts, zero averages, an inverted gate, warn levels and a long %s",
             "hold-off were run.");
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/gefr_pkg.sv
hdl/gefr_queue.sv
hdl/gefr_front.sv
hdl/gefr_back.sv
hdl/gated_echo_average_framer.sv
dv/gefr_frame_checker.sv
dv/tb_gated_echo_average_framer.sv
